FILE: rtl/core/glvdm_pkg.sv
// ----------------------------------------------------------------------------
// glvdm_pkg
// Shared constants and types for the GLV lambda divide/modulo pipeline.
// ----------------------------------------------------------------------------
package glvdm_pkg;

  // limb arithmetic
  localparam int LimbW   = 30;
  localparam int NumLimb = 5;
  localparam int ProdW   = 2 * LimbW;
  localparam int ColW    = ProdW + 3;

  // scalar >> HShift feeds the estimate
  localparam int HShift  = 121;
  localparam int ScalarW = 256;

  // estimate columns 3..8 are formed
  localparam int FirstCol = 3;
  localparam int NumCol   = 6;
  localparam int EstW     = 150;
  localparam int EstShift = 16;
  localparam int QuoEstW  = EstW - EstShift;

  localparam int QuoW = 128;
  localparam int RemW = 144;

  localparam int CorrSteps = 4;

  // pipeline sizes
  localparam int FrontStages = 4;
  localparam int QueueDepth  = 4;
  localparam int BackStages  = 4 + CorrSteps;

  localparam logic [126:0] Lambda = 127'h452217CC_90000001_0A118000_00000000;

  // lambda in 30-bit limbs, least significant first
  localparam logic [LimbW-1:0] LamLimb [NumLimb] = '{
    30'h00000000, 30'h28460000, 30'h00000010, 30'h0885F324, 30'h00000045
  };

  // floor(2^257 / lambda) in 30-bit limbs, least significant first
  localparam logic [LimbW-1:0] RecipLimb [NumLimb] = '{
    30'h1F203058, 30'h3B976995, 30'h3A6E2C0F, 30'h3BD54B4F, 30'h00000767
  };

  // request passed from the estimate front to the back
  typedef struct packed {
    logic [RemW-1:0]    scalar;
    logic [QuoEstW-1:0] quo_est;
  } front_item_t;

endpackage

FILE: rtl/core/glvdm_front.sv
// ----------------------------------------------------------------------------
// glvdm_front
// Quotient estimate: high columns of (scalar >> 121) * reciprocal, shifted.
// ----------------------------------------------------------------------------
module glvdm_front
  import glvdm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] scalar_word0,
  input  logic [63:0] scalar_word1,
  input  logic [63:0] scalar_word2,
  input  logic [63:0] scalar_word3,
  output logic        push,
  output front_item_t item,
  input  logic        q_full
);

  logic [ScalarW-1:0] s_in;
  logic [LimbW-1:0]   h [NumLimb];
  logic               adv;
  logic [FrontStages-1:0] vld;

  logic [ProdW-1:0] prod [NumCol][NumLimb];
  logic [RemW-1:0]  f1_scalar;
  logic [ColW-1:0]  col_sum [NumCol];
  logic [ColW-1:0]  col [NumCol];
  logic [RemW-1:0]  f2_scalar;
  logic [EstW-1:0]  e_sum;
  logic [EstW-1:0]  o_sum;
  logic [RemW-1:0]  f3_scalar;
  logic [EstW-1:0]  est;

  // stall only when the last stage holds a request the queue cannot take
  assign adv      = !vld[FrontStages-1] || !q_full;
  assign in_ready = adv;
  assign push     = vld[FrontStages-1] && !q_full;

  // scalar >> 121 as 30-bit limbs, top limb 15 bits
  always_comb begin
    s_in = {scalar_word3, scalar_word2, scalar_word1, scalar_word0};
    for (int j = 0; j < NumLimb - 1; j++) begin
      h[j] = s_in[HShift + j * LimbW +: LimbW];
    end
    h[NumLimb-1] = LimbW'(s_in[ScalarW-1:HShift + (NumLimb - 1) * LimbW]);
  end

  // valid shift register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[FrontStages-2:0], in_valid};
    end
  end

  // stage 1: partial products, grouped by column
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NumCol; c++) begin
        for (int j = 0; j < NumLimb; j++) begin
          if ((c + FirstCol >= j) && (c + FirstCol - j < NumLimb)) begin
            prod[c][j] <= ProdW'(h[j]) * ProdW'(RecipLimb[c + FirstCol - j]);
          end else begin
            prod[c][j] <= '0;
          end
        end
      end
      f1_scalar <= s_in[RemW-1:0];
    end
  end

  // stage 2: column sums
  always_comb begin
    for (int c = 0; c < NumCol; c++) begin
      col_sum[c] = '0;
      for (int j = 0; j < NumLimb; j++) begin
        col_sum[c] = col_sum[c] + ColW'(prod[c][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col       <= col_sum;
      f2_scalar <= f1_scalar;
    end
  end

  // stage 3: even and odd columns, carry out of column 3 kept
  always_ff @(posedge clk) begin
    if (adv) begin
      e_sum <= EstW'(col[1]) + (EstW'(col[3]) << (2 * LimbW))
             + (EstW'(col[5]) << (4 * LimbW));
      o_sum <= EstW'(col[0] >> LimbW) + (EstW'(col[2]) << LimbW)
             + (EstW'(col[4]) << (3 * LimbW));
      f3_scalar <= f2_scalar;
    end
  end

  // stage 4: estimate, shifted down
  assign est = e_sum + o_sum;

  always_ff @(posedge clk) begin
    if (adv) begin
      item.scalar  <= f3_scalar;
      item.quo_est <= est[EstW-1:EstShift];
    end
  end

endmodule

FILE: rtl/core/glvdm_queue.sv
// ----------------------------------------------------------------------------
// glvdm_queue
// Small FIFO between the estimate front and the multiply-back pipeline.
// ----------------------------------------------------------------------------
module glvdm_queue
  import glvdm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  front_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output front_item_t head_item
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  front_item_t     mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == CntW'(QueueDepth));
  assign not_empty = (count != '0);
  assign head_item = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: rtl/core/glvdm_back.sv
// ----------------------------------------------------------------------------
// glvdm_back
// Multiply the estimate back by lambda, subtract, and correct the remainder.
// ----------------------------------------------------------------------------
module glvdm_back
  import glvdm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        pop,
  input  front_item_t head_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] quotient_low,
  output logic [63:0] quotient_high,
  output logic [63:0] remainder_low,
  output logic [62:0] remainder_high
);

  logic                  adv;
  logic [BackStages-1:0] vld;
  logic [LimbW-1:0]      gl [NumLimb];

  logic [ProdW-1:0] prod [NumLimb][NumLimb];
  logic [RemW-1:0]  b1_scalar;
  logic [QuoW-1:0]  b1_quo;
  logic [ColW-1:0]  col_sum [NumLimb];
  logic [ColW-1:0]  col [NumLimb];
  logic [RemW-1:0]  b2_scalar;
  logic [QuoW-1:0]  b2_quo;
  logic [RemW-1:0]  e_sum;
  logic [RemW-1:0]  o_sum;
  logic [RemW-1:0]  b3_scalar;
  logic [QuoW-1:0]  b3_quo;
  logic [RemW-1:0]  rem [CorrSteps+1];
  logic [QuoW-1:0]  quo [CorrSteps+1];

  // last stage is the output register
  assign adv       = !vld[BackStages-1] || out_ready;
  assign pop       = adv && q_valid;
  assign out_valid = vld[BackStages-1];

  // estimate as 30-bit limbs, top limb 14 bits
  always_comb begin
    for (int j = 0; j < NumLimb - 1; j++) begin
      gl[j] = head_item.quo_est[j * LimbW +: LimbW];
    end
    gl[NumLimb-1] = LimbW'(head_item.quo_est[QuoEstW-1:(NumLimb - 1) * LimbW]);
  end

  // valid shift register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[BackStages-2:0], q_valid};
    end
  end

  // stage 1: partial products of q * lambda, low columns only
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NumLimb; c++) begin
        for (int j = 0; j < NumLimb; j++) begin
          if (j <= c) begin
            prod[c][j] <= ProdW'(gl[j]) * ProdW'(LamLimb[c - j]);
          end else begin
            prod[c][j] <= '0;
          end
        end
      end
      b1_scalar <= head_item.scalar;
      b1_quo    <= head_item.quo_est[QuoW-1:0];
    end
  end

  // stage 2: column sums
  always_comb begin
    for (int c = 0; c < NumLimb; c++) begin
      col_sum[c] = '0;
      for (int j = 0; j < NumLimb; j++) begin
        col_sum[c] = col_sum[c] + ColW'(prod[c][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col       <= col_sum;
      b2_scalar <= b1_scalar;
      b2_quo    <= b1_quo;
    end
  end

  // stage 3: even and odd columns of the product, mod 2^144
  always_ff @(posedge clk) begin
    if (adv) begin
      e_sum <= RemW'(col[0]) + (RemW'(col[2]) << (2 * LimbW))
             + (RemW'(col[4]) << (4 * LimbW));
      o_sum <= (RemW'(col[1]) << LimbW) + (RemW'(col[3]) << (3 * LimbW));
      b3_scalar <= b2_scalar;
      b3_quo    <= b2_quo;
    end
  end

  // stage 4: first remainder over 144 bits, then correction stages that
  // subtract lambda while bits 143..127 are not clear
  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= b3_scalar - e_sum - o_sum;
      quo[0] <= b3_quo;
      for (int i = 0; i < CorrSteps; i++) begin
        if (|rem[i][RemW-1:127]) begin
          rem[i+1] <= rem[i] - RemW'(Lambda);
          quo[i+1] <= quo[i] + 1'b1;
        end else begin
          rem[i+1] <= rem[i];
          quo[i+1] <= quo[i];
        end
      end
    end
  end

  assign quotient_low   = quo[CorrSteps][63:0];
  assign quotient_high  = quo[CorrSteps][127:64];
  assign remainder_low  = rem[CorrSteps][63:0];
  assign remainder_high = rem[CorrSteps][126:64];

endmodule

FILE: rtl/core/glv_scalar_lambda_divmod.sv
// Path from input acceptance to output: 4 estimate stages, one queue slot,
// then 8 multiply-back and correction stages.
// Throughput: one request per cycle; the 4-entry queue lets the estimate front
// keep running while the output is stalled, until the queue fills.
// Reset: synchronous, active high; clears all valid bits and the queue
// pointers, so no result is shown after reset. Payload registers are not reset.
// ----------------------------------------------------------------------------
// glv_scalar_lambda_divmod
// Splits a 256-bit scalar into q and r = scalar - q * lambda, Barrett style.
// ----------------------------------------------------------------------------
module glv_scalar_lambda_divmod
  import glvdm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] scalar_word0,
  input  logic [63:0] scalar_word1,
  input  logic [63:0] scalar_word2,
  input  logic [63:0] scalar_word3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] quotient_low,
  output logic [63:0] quotient_high,
  output logic [63:0] remainder_low,
  output logic [62:0] remainder_high
);

  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_valid;
  front_item_t front_item;
  front_item_t head_item;

  // estimate front
  glvdm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .scalar_word0 (scalar_word0),
    .scalar_word1 (scalar_word1),
    .scalar_word2 (scalar_word2),
    .scalar_word3 (scalar_word3),
    .push         (push),
    .item         (front_item),
    .q_full       (q_full)
  );

  // decoupling queue
  glvdm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head_item (head_item)
  );

  // multiply-back, subtract and correct
  glvdm_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .pop            (pop),
    .head_item      (head_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .quotient_low   (quotient_low),
    .quotient_high  (quotient_high),
    .remainder_low  (remainder_low),
    .remainder_high (remainder_high)
  );

endmodule

FILE: rtl/core/glvdm_checker.sv
// ----------------------------------------------------------------------------
// glvdm_checker
// Port-level checks on the divmod block, bound to the top level.
// ----------------------------------------------------------------------------
module glvdm_checker
  import glvdm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] quotient_low,
  input logic [63:0] quotient_high,
  input logic [63:0] remainder_low,
  input logic [62:0] remainder_high
);

  localparam int Capacity = FrontStages + QueueDepth + BackStages;
  localparam int CntW     = $clog2(Capacity + 1);

  logic            in_acc;
  logic            out_acc;
  logic [CntW-1:0] in_flight;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // requests accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else if (in_acc && !out_acc) begin
      in_flight <= in_flight + 1'b1;
    end else if (out_acc && !in_acc) begin
      in_flight <= in_flight - 1'b1;
    end
  end

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(quotient_low) && $stable(quotient_high)
      && $stable(remainder_low) && $stable(remainder_high))
    else $error("result changed while stalled");

  // no result without an accepted request
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_flight != '0)
    else $error("result without a pending request");

  // the block never holds more requests than it has slots
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    in_flight <= CntW'(Capacity))
    else $error("more requests in flight than pipeline slots");

  // nothing is shown right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind glv_scalar_lambda_divmod glvdm_checker u_glvdm_checker (.*);
